/* design/lfu_cache_lookup_insert_macros.svh */
// ----------------------------------------------------------------------------
// LFU cache assertion macros
// Shared property wrappers, clocked on i_clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef LFU_CACHE_LOOKUP_INSERT_MACROS_SVH
`define LFU_CACHE_LOOKUP_INSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LFU_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lfu cache: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define LFU_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lfu cache: next-cycle check failed");

`endif

/* design/lfu_pkg.sv */
// ----------------------------------------------------------------------------
// LFU cache package
// Sizes, codes and controller/datapath command types.
// ----------------------------------------------------------------------------
`default_nettype none

package lfu_pkg;

    localparam int ENTRIES     = 16;
    localparam int COUNT_WIDTH = 16;
    localparam int KEY_W       = 32;
    localparam int DATA_W      = 32;
    localparam int CFG_W       = 5;

    localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OCC_W    = $clog2(ENTRIES + 1);
    localparam int LEAVES   = 1 << IDX_W;
    localparam int NODES    = 2 * LEAVES - 1;
    localparam int NKEY_W   = 1 + COUNT_WIDTH + IDX_W;
    // edges for an entry change to reach the tree root
    localparam int TREE_LAT = IDX_W + 1;
    localparam int SETTLE_W = $clog2(TREE_LAT + 1);

    localparam logic [CFG_W-1:0]       CAP_RESET  = CFG_W'(16);
    localparam logic [DATA_W-1:0]      MISS_VALUE = '1;
    localparam logic [COUNT_WIDTH-1:0] COUNT_ONE  = COUNT_WIDTH'(1);

    typedef enum logic {
        ACT_GET = 1'b0,
        ACT_PUT = 1'b1
    } t_action;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MATCH,
        S_UPDATE
    } t_state;

    typedef struct packed {
        logic capture;
        logic match;
        logic update;
    } t_dp_cmd;

endpackage

`default_nettype wire

/* design/lfu_cache_lookup_insert.sv */
// ----------------------------------------------------------------------------
// LFU cache lookup/insert
// Fully associative key/value cache, least-frequently-used replacement with
// least-recently-used tie-break.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_axis channel: tdata = {value, key}, tuser = action
//   (get or put). One response beat leaves on m_axis per request: tdata =
//   {evicted_key, read_value}, tuser = {evicted, hit}.
//   The capacity register is written through i_cfg_wr_en / i_cfg_wr_data;
//   the user must write it only while no request is in flight (not enforced).
//   Sequence: a request beat is captured in S_IDLE, matched in S_MATCH once the
//   victim tree has settled, and applied in S_UPDATE, which loads the result
//   register and then raises its valid. A new request is taken only after the
//   last one has been applied, and its match waits for the registered min tree
//   to reflect the last update before the next replacement decision. Reset: all
//   entries invalid, occupancy zero, capacity 16; the first request waits in S_MATCH for the tree to fill.
//   Stall: a held response sits in the result register; the next request is
//   still taken and its match done, but it is not applied until that response
//   has been accepted downstream.
// ----------------------------------------------------------------------------
`default_nettype none

module lfu_cache_lookup_insert
    import lfu_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    // request channel
    input  wire logic                    i_s_axis_tvalid,
    output logic                         o_s_axis_tready,
    input  wire logic [KEY_W+DATA_W-1:0] i_s_axis_tdata,  // key, value
    input  wire logic                    i_s_axis_tuser,  // action
    // response channel
    output logic                         o_m_axis_tvalid,
    input  wire logic                    i_m_axis_tready,
    output logic [DATA_W+KEY_W-1:0]      o_m_axis_tdata,  // read_value, evicted_key
    output logic [1:0]                   o_m_axis_tuser,  // hit, evicted
    // capacity register
    input  wire logic                    i_cfg_wr_en,
    input  wire logic [CFG_W-1:0]        i_cfg_wr_data
);

    t_dp_cmd           cmd;
    logic              res_hit;
    logic              res_ev;
    logic [DATA_W-1:0] res_rd;
    logic [KEY_W-1:0]  res_evkey;

    // sequencing and response valid
    lfu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .o_s_tready (o_s_axis_tready),
        .i_m_tready (i_m_axis_tready),
        .o_m_tvalid (o_m_axis_tvalid),
        .o_cmd      (cmd)
    );

    // entries, match, victim tree and result beat
    lfu_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_action      (i_s_axis_tuser),
        .i_key         (i_s_axis_tdata[KEY_W-1:0]),
        .i_value       (i_s_axis_tdata[KEY_W+DATA_W-1:KEY_W]),
        .o_hit         (res_hit),
        .o_read_value  (res_rd),
        .o_evicted     (res_ev),
        .o_evicted_key (res_evkey)
    );

    assign o_m_axis_tdata = {res_evkey, res_rd};
    assign o_m_axis_tuser = {res_ev, res_hit};

endmodule

`default_nettype wire

/* design/lfu_ctrl.sv */
// ----------------------------------------------------------------------------
// LFU cache controller
// Request sequencing, victim-tree settle timer and result register valid.
// ----------------------------------------------------------------------------
`default_nettype none
`include "lfu_cache_lookup_insert_macros.svh"

module lfu_ctrl
    import lfu_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_s_tvalid,
    output logic         o_s_tready,
    input  wire logic    i_m_tready,
    output logic         o_m_tvalid,
    output t_dp_cmd      o_cmd
);

    t_state              r_state, n_state;
    logic [SETTLE_W-1:0] r_settle;
    logic                r_out_valid;
    logic                go;

    // tree root must be current and the result register free or being accepted
    assign go = (r_settle == '0) && (!r_out_valid || i_m_tready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) n_state = S_MATCH;
            end
            S_MATCH: begin
                if (go) n_state = S_UPDATE;
            end
            S_UPDATE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_s_tready     = 1'b0;
        o_cmd          = '0;
        case (r_state)
            S_IDLE: begin
                o_s_tready  = 1'b1;
                o_cmd.capture = i_s_tvalid;
            end
            S_MATCH: begin
                o_cmd.match = 1'b1;
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
            end
            default: begin
                o_s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_settle    <= SETTLE_W'(TREE_LAT);
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_UPDATE) begin
                r_settle <= SETTLE_W'(TREE_LAT);
            end else if (r_settle != '0) begin
                r_settle <= r_settle - SETTLE_W'(1);
            end
            if (r_state == S_UPDATE) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;

    `LFU_ASSERT_SAME(a_update_into_free_slot, r_state == S_UPDATE, !r_out_valid)
    `LFU_ASSERT_NEXT(a_hold_until_settled, (r_state == S_MATCH) && (r_settle != '0), r_state == S_MATCH)

endmodule

`default_nettype wire

/* design/lfu_dpath.sv */
// ----------------------------------------------------------------------------
// LFU cache datapath
// Entry registers, key match, registered victim tree and result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "lfu_cache_lookup_insert_macros.svh"

module lfu_dpath
    import lfu_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_dp_cmd           i_cmd,
    input  wire logic              i_cfg_wr_en,
    input  wire logic [CFG_W-1:0]  i_cfg_wr_data,
    input  wire logic              i_action,
    input  wire logic [KEY_W-1:0]  i_key,
    input  wire logic [DATA_W-1:0] i_value,
    output logic                   o_hit,
    output logic [DATA_W-1:0]      o_read_value,
    output logic                   o_evicted,
    output logic [KEY_W-1:0]       o_evicted_key
);

    logic [CFG_W-1:0]       r_cap_cfg;

    logic [ENTRIES-1:0]     r_valid;
    logic [OCC_W-1:0]       r_occ;
    logic [KEY_W-1:0]       r_key   [ENTRIES];
    logic [DATA_W-1:0]      r_data  [ENTRIES];
    logic [COUNT_WIDTH-1:0] r_count [ENTRIES];
    logic [IDX_W-1:0]       r_rank  [ENTRIES];

    t_action                r_in_action;
    logic [KEY_W-1:0]       r_in_key;
    logic [DATA_W-1:0]      r_in_value;

    logic                   r_hit;
    logic [IDX_W-1:0]       r_midx;

    logic [NKEY_W-1:0]      r_node_key [NODES];
    logic [IDX_W-1:0]       r_node_idx [NODES];

    logic                   r_res_hit;
    logic [DATA_W-1:0]      r_res_rd;
    logic                   r_res_ev;
    logic [KEY_W-1:0]       r_res_evkey;

    logic                   m_hit;
    logic [IDX_W-1:0]       m_idx;
    logic [IDX_W-1:0]       free_idx;
    logic [OCC_W-1:0]       cap;
    logic                   is_put;
    logic                   cap_on;
    logic                   do_touch;
    logic                   do_fill;
    logic                   do_evict;
    logic                   promote;
    logic [IDX_W-1:0]       promote_idx;
    logic [IDX_W-1:0]       base_rank;
    logic [IDX_W-1:0]       top_rank;
    logic [IDX_W-1:0]       victim;

    // capacity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap_cfg <= CAP_RESET;
        end else if (i_cfg_wr_en) begin
            r_cap_cfg <= i_cfg_wr_data;
        end
    end

    assign cap = (32'(r_cap_cfg) > 32'(ENTRIES)) ? OCC_W'(ENTRIES) : OCC_W'(r_cap_cfg);

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_in_action <= t_action'(i_action);
            r_in_key    <= i_key;
            r_in_value  <= i_value;
        end
    end

    // parallel key compare
    always_comb begin
        m_hit = 1'b0;
        m_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (r_valid[i] && (r_key[i] == r_in_key)) begin
                m_hit = 1'b1;
                m_idx = IDX_W'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.match) begin
            r_hit  <= m_hit;
            r_midx <= m_idx;
        end
    end

    // first free slot
    always_comb begin
        free_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (!r_valid[i]) free_idx = IDX_W'(i);
        end
    end

    // victim tree: heap of registered min nodes, key {invalid, count, rank};
    // an empty slot enters as all ones, whatever its stale payload holds
    for (genvar n = 0; n < NODES; n++) begin : g_node
        if (n < LEAVES - 1) begin : g_int
            always_ff @(posedge i_clk) begin
                if (r_node_key[2*n+1] <= r_node_key[2*n+2]) begin
                    r_node_key[n] <= r_node_key[2*n+1];
                    r_node_idx[n] <= r_node_idx[2*n+1];
                end else begin
                    r_node_key[n] <= r_node_key[2*n+2];
                    r_node_idx[n] <= r_node_idx[2*n+2];
                end
            end
        end else if (n - (LEAVES - 1) < ENTRIES) begin : g_leaf
            localparam int L = n - (LEAVES - 1);
            always_ff @(posedge i_clk) begin
                r_node_key[n] <= r_valid[L] ? {1'b0, r_count[L], r_rank[L]} : '1;
                r_node_idx[n] <= IDX_W'(L);
            end
        end else begin : g_pad
            always_ff @(posedge i_clk) begin
                r_node_key[n] <= '1;
                r_node_idx[n] <= '0;
            end
        end
    end

    assign victim = r_node_idx[0];

    // update decode
    assign is_put      = (r_in_action == ACT_PUT);
    assign cap_on      = (cap != '0);
    assign do_touch    = r_hit && (!is_put || cap_on);
    assign do_fill     = is_put && cap_on && !r_hit && (r_occ < cap);
    assign do_evict    = is_put && cap_on && !r_hit && !(r_occ < cap);
    assign promote     = do_touch || do_evict;
    assign promote_idx = do_touch ? r_midx : victim;
    assign base_rank   = r_rank[promote_idx];
    assign top_rank    = IDX_W'(r_occ - OCC_W'(1));

    // control state of the entries
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_occ   <= '0;
        end else if (i_cmd.update && do_fill) begin
            r_valid[free_idx] <= 1'b1;
            r_occ             <= r_occ + OCC_W'(1);
        end
    end

    // entry payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            if (promote) begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (r_valid[i] && (IDX_W'(i) != promote_idx) &&
                        (r_rank[i] > base_rank)) begin
                        r_rank[i] <= r_rank[i] - IDX_W'(1);
                    end
                end
                r_rank[promote_idx] <= top_rank;
            end
            if (do_touch) begin
                if (r_count[r_midx] != '1) r_count[r_midx] <= r_count[r_midx] + COUNT_ONE;
                if (is_put) r_data[r_midx] <= r_in_value;
            end
            if (do_evict) begin
                r_key[victim]   <= r_in_key;
                r_data[victim]  <= r_in_value;
                r_count[victim] <= COUNT_ONE;
            end
            if (do_fill) begin
                r_key[free_idx]   <= r_in_key;
                r_data[free_idx]  <= r_in_value;
                r_count[free_idx] <= COUNT_ONE;
                r_rank[free_idx]  <= IDX_W'(r_occ);
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            r_res_hit   <= r_hit;
            r_res_rd    <= (!is_put && r_hit) ? r_data[r_midx] : MISS_VALUE;
            r_res_ev    <= do_evict;
            r_res_evkey <= do_evict ? r_key[victim] : '0;
        end
    end

    assign o_hit         = r_res_hit;
    assign o_read_value  = r_res_rd;
    assign o_evicted     = r_res_ev;
    assign o_evicted_key = r_res_evkey;

    `LFU_ASSERT_SAME(a_occ_matches_valid, 1'b1, $countones(r_valid) == 32'(r_occ))
    `LFU_ASSERT_SAME(a_occ_in_range, 1'b1, 32'(r_occ) <= 32'(ENTRIES))

endmodule

`default_nettype wire
